FILE: hw/rtl/pctd_pkg.sv
`default_nettype none

package pctd_pkg;

  // Fixed field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 4;
  localparam int unsigned CODE_W = 8;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_CODE_LENGTH_DEF = 8;
  localparam int unsigned SYMBOL_WIDTH_DEF    = 8;

  typedef enum logic {
    ACT_LOAD   = 1'b0,
    ACT_DECODE = 1'b1
  } action_e;

  typedef struct packed {
    action_e             action;
    logic [BYTE_W-1:0]   entry_symbol;
    logic [LEN_W-1:0]    entry_length;
    logic [CODE_W-1:0]   entry_code;
    logic [BYTE_W-1:0]   data_byte;
    logic [LEN_W-1:0]    valid_bits;
  } pctd_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] symbol;
    logic              code_error;
    logic              last_of_run;
  } pctd_out_t;

endpackage

`default_nettype wire

FILE: hw/rtl/prefix_code_table_decoder_top.sv
`default_nettype none

// Channel | Direction | Handshake                    | Payload
// --------+-----------+------------------------------+----------------------
// in      | input     | in_valid_i / in_ready_o      | in_item_i  (pctd_in_t)
// out     | output    | out_valid_o / out_ready_i    | out_item_o (pctd_out_t)
//
// A load item writes its table entry if its length is valid. A decode item with n
// valid bits (capped at 8) issues the first table read, passes each bit through
// the table memory's read-decide loop, then releases the held last result, if any.
// After reset the table, all MAX_CODE_LENGTH * 256 entries, is swept clear with
// in_ready_o low. The bit loop stalls while the output register is full and
// not being taken; the input side accepts only between decode items.

module prefix_code_table_decoder_top #(
  parameter int unsigned MAX_CODE_LENGTH = pctd_pkg::MAX_CODE_LENGTH_DEF,
  parameter int unsigned SYMBOL_WIDTH    = pctd_pkg::SYMBOL_WIDTH_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  pctd_pkg::pctd_in_t  in_item_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output pctd_pkg::pctd_out_t out_item_o
);

  localparam int unsigned BYTE_W = pctd_pkg::BYTE_W;
  localparam int unsigned LEN_W  = pctd_pkg::LEN_W;
  localparam int unsigned CODE_W = pctd_pkg::CODE_W;
  // One row of 256 codes for each code length
  localparam int unsigned DEPTH  = MAX_CODE_LENGTH * (2 ** CODE_W);
  localparam int unsigned AW     = $clog2(DEPTH);
  localparam int unsigned ACC_W  = MAX_CODE_LENGTH;
  localparam int unsigned ENT_W  = SYMBOL_WIDTH + 1;

  localparam logic [LEN_W-1:0] MAX_LEN  = LEN_W'(MAX_CODE_LENGTH);
  localparam logic [LEN_W-1:0] BYTE_LEN = LEN_W'(BYTE_W);
  localparam logic [LEN_W-1:0] ONE_LEN  = LEN_W'(1);
  localparam logic [AW-1:0]    LAST_ADR = AW'(DEPTH - 1);

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  // Table address: (length - 1) selects the row, the code the column.
  function automatic logic [AW-1:0] tbl_idx(logic [LEN_W-1:0] len,
                                            logic [CODE_W-1:0] code);
    logic [LEN_W-1:0] lm1;
    lm1 = len - ONE_LEN;
    return AW'({lm1, code});
  endfunction

  // Control state
  logic [1:0]        state_q, state_d;
  logic [AW-1:0]     clr_cnt_q, clr_cnt_d;
  logic [LEN_W-1:0]  pend_len_q, pend_len_d;
  logic [ACC_W-1:0]  pend_bits_q, pend_bits_d;
  logic [LEN_W-1:0]  left_q, left_d;
  logic              held_v_q, held_v_d;
  logic              out_valid_q, out_valid_d;

  // Payload
  logic [BYTE_W-1:0]   byte_q, byte_d;
  pctd_pkg::pctd_out_t held_q, held_d;
  pctd_pkg::pctd_out_t out_q, out_d;

  // Table memory: bit SYMBOL_WIDTH is the valid mark
  logic [ENT_W-1:0] code_table_q [DEPTH];
  logic [ENT_W-1:0] rd0_q, rd1_q;
  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr0, mem_raddr1;
  logic [ENT_W-1:0] mem_wdata;

  logic              in_acc, out_free;
  logic [LEN_W-1:0]  nbits;
  logic              ld_ok;
  logic [CODE_W-1:0] ld_mask;
  logic [ENT_W-1:0]  entry;
  logic [LEN_W-1:0]  run_len;
  logic [ACC_W-1:0]  run_acc;
  logic              hit, err, res;
  logic [LEN_W-1:0]  iss_len;
  logic [ACC_W-1:0]  iss_acc;
  logic              iss_bit;
  logic [ACC_W-1:0]  iss_next;
  pctd_pkg::pctd_out_t res_item;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  assign nbits   = (in_item_i.valid_bits > BYTE_LEN) ? BYTE_LEN : in_item_i.valid_bits;
  assign ld_ok   = (in_item_i.entry_length != '0) && (in_item_i.entry_length <= MAX_LEN);
  assign ld_mask = CODE_W'((9'd1 << in_item_i.entry_length) - 9'd1);

  // With nothing pending both reads hit the same address; otherwise port 0
  // holds the candidate for a cleared accumulator and port 1 the carried one.
  assign entry   = (pend_len_q == '0) ? rd0_q : rd1_q;
  assign run_len = pend_len_q + ONE_LEN;
  assign run_acc = ACC_W'({pend_bits_q, byte_q[BYTE_W-1]});
  assign hit     = entry[SYMBOL_WIDTH];
  assign err     = !hit && (run_len == MAX_LEN);
  assign res     = hit || err;

  always_comb begin
    res_item             = '0;
    res_item.code_error  = err;
    if (hit) begin
      res_item.symbol = BYTE_W'(entry[SYMBOL_WIDTH-1:0]);
    end
  end

  // Read addresses for the next bit, for both outcomes of the current bit
  always_comb begin
    if (state_q == S_RUN) begin
      iss_len = run_len;
      iss_acc = run_acc;
      iss_bit = byte_q[BYTE_W-2];
    end else begin
      iss_len = pend_len_q;
      iss_acc = pend_bits_q;
      iss_bit = in_item_i.data_byte[BYTE_W-1];
    end
    iss_next   = ACC_W'({iss_acc, iss_bit});
    mem_raddr0 = tbl_idx(ONE_LEN, CODE_W'(iss_bit));
    mem_raddr1 = (iss_len >= MAX_LEN) ? mem_raddr0
                                      : tbl_idx(iss_len + ONE_LEN, CODE_W'(iss_next));
  end

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    pend_len_d  = pend_len_q;
    pend_bits_d = pend_bits_q;
    left_d      = left_q;
    held_v_d    = held_v_q;
    held_d      = held_q;
    byte_d      = byte_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = clr_cnt_q;
    mem_wdata   = '0;

    unique case (state_q)
      S_CLEAR: begin
        // Sweep the valid marks clear, one entry a cycle
        mem_we    = 1'b1;
        clr_cnt_d = clr_cnt_q + AW'(1);
        if (clr_cnt_q == LAST_ADR) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_item_i.action == pctd_pkg::ACT_LOAD) begin
            mem_we    = ld_ok;
            mem_waddr = tbl_idx(in_item_i.entry_length, in_item_i.entry_code & ld_mask);
            mem_wdata = {1'b1, in_item_i.entry_symbol[SYMBOL_WIDTH-1:0]};
          end else if (nbits != '0) begin
            mem_re  = 1'b1;
            byte_d  = in_item_i.data_byte;
            left_d  = nbits;
            state_d = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (out_free) begin
          if (res) begin
            pend_len_d  = '0;
            pend_bits_d = '0;
            // Hold the new result; release the previous one, not last
            if (held_v_q) begin
              out_valid_d = 1'b1;
              out_d       = held_q;
            end
            held_v_d = 1'b1;
            held_d   = res_item;
          end else begin
            pend_len_d  = run_len;
            pend_bits_d = run_acc;
          end
          if (left_q == ONE_LEN) begin
            state_d = S_FLUSH;
          end else begin
            mem_re = 1'b1;
            left_d = left_q - ONE_LEN;
            byte_d = byte_q << 1;
          end
        end
      end
      S_FLUSH: begin
        if (!held_v_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d       = 1'b1;
          out_d             = held_q;
          out_d.last_of_run = 1'b1;
          held_v_d          = 1'b0;
          state_d           = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      pend_len_q  <= '0;
      pend_bits_q <= '0;
      left_q      <= '0;
      held_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      pend_len_q  <= pend_len_d;
      pend_bits_q <= pend_bits_d;
      left_q      <= left_d;
      held_v_q    <= held_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    held_q <= held_d;
    out_q  <= out_d;
  end

  // Table memory, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      code_table_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd0_q <= code_table_q[mem_raddr0];
      rd1_q <= code_table_q[mem_raddr1];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/pctd_checker.sv
`default_nettype none

module pctd_checker (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_ready_o,
  input pctd_pkg::pctd_in_t  in_item_i,
  input wire                 out_valid_o,
  input wire                 out_ready_i,
  input pctd_pkg::pctd_out_t out_item_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_item_o))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.code_error |-> out_item_o.symbol == '0)
    else $error("error result carries a symbol");

  a_decode_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_item_i.action == pctd_pkg::ACT_DECODE && in_item_i.valid_bits != '0
    |=> !in_ready_o)
    else $error("input taken during a decode run");

  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_item_i.action == pctd_pkg::ACT_LOAD |=> in_ready_o)
    else $error("load item stalled the input");

endmodule

bind prefix_code_table_decoder_top pctd_checker u_pctd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

`default_nettype wire
